@@ design/rwn_pkg.sv @@
// rwn_pkg: shared constants, codes and helper functions for the radial
// wavefunction normaliser; no dependencies
package rwn_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam int MUL_AW = 128;
    localparam int MUL_BW = 64;
    localparam int MUL_CW = $clog2(MUL_BW + 1);

    localparam int DIV_NW = 97;
    localparam int DIV_DW = 64;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    localparam int SQ_RW = 98;
    localparam int SQ_QW = SQ_RW / 2;
    localparam int SQ_CW = $clog2(SQ_QW + 1);

    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] REG_GRID_LOG   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_STEP_WIDTH = 2'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_ZERO  = 2'd1;
    localparam logic [1:0] STATUS_EARLY = 2'd2;

    localparam logic [31:0] STEP_RESET = 32'h0100_0000;
    localparam logic [31:0] ONE_Q16    = 32'h0001_0000;

    // magnitude of a two's complement word, most negative maps to 2^31
    function automatic logic [31:0] mag32(input logic [31:0] v);
        logic [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        return m;
    endfunction

    // signed saturation of a sign and magnitude
    function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
        logic [31:0] r;
        if (neg)
        begin
            if (mag >= 64'h0000_0000_8000_0000)
                r = 32'h8000_0000;
            else
                r = 32'd0 - mag[31:0];
        end
        else
        begin
            if (mag > 64'h0000_0000_7FFF_FFFF)
                r = 32'h7FFF_FFFF;
            else
                r = mag[31:0];
        end
        return r;
    endfunction

endpackage

@@ design/rwn_ifs.sv @@
// rwn_ifs: request, response and register write channels
// depends on nothing
interface rwn_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] sample;
    logic        [31:0] radius;
    logic        [9:0]  index;
    logic               last;
    modport source (output valid, cmd, sample, radius, index, last, input ready);
    modport sink   (input valid, cmd, sample, radius, index, last, output ready);
endinterface

interface rwn_rsp_if;
    logic               valid;
    logic               ready;
    logic        [9:0]  out_index;
    logic signed [31:0] normalised;
    logic signed [31:0] rescaled;
    logic        [1:0]  status;
    modport source (output valid, out_index, normalised, rescaled, status, input ready);
    modport sink   (input valid, out_index, normalised, rescaled, status, output ready);
endinterface

interface rwn_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/radial_wavefunction_normaliser_core.sv @@
// radial_wavefunction_normaliser_core: sequencer, sum and scale registers
// depends on rwn_pkg, rwn_ifs, rwn_ram, rwn_mul, rwn_div, rwn_sqrt
//
// One word is handled at a time; the request channel is ready only between
// words. Multiplies, divides and square roots run bit-serially through one
// shared multiplier, divider and square root unit: a load runs 32+64+32
// multiplier bits, and on a log grid also 22 root bits and 48 quotient bits;
// a load marked last adds the scale (97 quotient bits, 49 root bits), and a
// read runs two 32-bit multiplies after the ram read.
// A finished response waits in its own register while the next word starts.
module radial_wavefunction_normaliser_core #(
    parameter int DEPTH = rwn_pkg::DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rwn_cfg_if.sink    cfg,
    rwn_req_if.sink    req,
    rwn_rsp_if.source  rsp
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL1  = 4'd1;
    localparam logic [3:0] ST_MUL2  = 4'd2;
    localparam logic [3:0] ST_MUL3  = 4'd3;
    localparam logic [3:0] ST_ROOT  = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_WRITE = 4'd6;
    localparam logic [3:0] ST_FIN   = 4'd7;
    localparam logic [3:0] ST_SDIV  = 4'd8;
    localparam logic [3:0] ST_SROOT = 4'd9;
    localparam logic [3:0] ST_ADDR  = 4'd10;
    localparam logic [3:0] ST_RMUL1 = 4'd11;
    localparam logic [3:0] ST_RMUL2 = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    logic [3:0]    state_reg;
    logic          grid_log_reg;
    logic [31:0]   step_reg;
    logic [63:0]   sum_reg;
    logic [31:0]   scale_reg;
    logic [CW-1:0] count_reg;
    logic          closed_reg;
    logic          mul_go_reg;
    logic          div_go_reg;
    logic          sq_go_reg;
    logic          out_valid_reg;

    logic [31:0]   sample_reg;
    logic [31:0]   smag_reg;
    logic [31:0]   rad_reg;
    logic          last_reg;
    logic [9:0]    idx_reg;
    logic [31:0]   root_reg;
    logic [31:0]   val_reg;
    logic [31:0]   norm_reg;
    logic [31:0]   resc_reg;
    logic [1:0]    status_reg;
    logic [9:0]    out_index_reg;
    logic [31:0]   out_norm_reg;
    logic [31:0]   out_resc_reg;
    logic [1:0]    out_status_reg;

    logic [rwn_pkg::MUL_AW-1:0]                 mul_a;
    logic [rwn_pkg::MUL_BW-1:0]                 mul_b;
    logic [rwn_pkg::MUL_CW-1:0]                 mul_n;
    logic [rwn_pkg::MUL_AW+rwn_pkg::MUL_BW-1:0] mul_prod;
    logic                                       mul_done;
    logic [rwn_pkg::DIV_NW-1:0]                 div_dvd;
    logic [rwn_pkg::DIV_DW-1:0]                 div_dvs;
    logic [rwn_pkg::DIV_CW-1:0]                 div_n;
    logic [rwn_pkg::DIV_NW-1:0]                 div_quot;
    logic                                       div_done;
    logic [rwn_pkg::SQ_RW-1:0]                  sq_x;
    logic [rwn_pkg::SQ_CW-1:0]                  sq_n;
    logic [rwn_pkg::SQ_QW-1:0]                  sq_root;
    logic                                       sq_done;

    logic          ram_we;
    logic [31:0]   v_rd;
    logic [31:0]   root_rd;
    logic [63:0]   term;
    logic [64:0]   sum_add;
    logic          accept;
    logic          full;

    assign accept  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign full    = !closed_reg && (count_reg == CW'(DEPTH));
    assign ram_we  = (state_reg == ST_WRITE);
    assign term    = (|mul_prod[191:136]) ? 64'hFFFF_FFFF_FFFF_FFFF : mul_prod[135:72];
    assign sum_add = {1'b0, sum_reg} + {1'b0, term};

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_n   = '0;
        div_dvd = '0;
        div_dvs = '0;
        div_n   = '0;
        sq_x    = '0;
        sq_n    = '0;
        case (state_reg)
            ST_MUL1:
            begin
                mul_a = rwn_pkg::MUL_AW'(smag_reg);
                mul_b = {rad_reg, 32'd0};
                mul_n = rwn_pkg::MUL_CW'(32);
            end
            ST_MUL2:
            begin
                mul_a = rwn_pkg::MUL_AW'(mul_prod[63:0]);
                mul_b = mul_prod[63:0];
                mul_n = rwn_pkg::MUL_CW'(64);
            end
            ST_MUL3:
            begin
                mul_a = mul_prod[127:0];
                mul_b = {step_reg, 32'd0};
                mul_n = rwn_pkg::MUL_CW'(32);
            end
            ST_ROOT:
            begin
                sq_x = {rad_reg, 12'd0, 54'd0};
                sq_n = rwn_pkg::SQ_CW'(22);
            end
            ST_DIV:
            begin
                div_dvd = {smag_reg, 16'd0, 49'd0};
                div_dvs = rwn_pkg::DIV_DW'(root_reg);
                div_n   = rwn_pkg::DIV_CW'(48);
            end
            ST_SDIV:
            begin
                div_dvd = {1'b1, 96'd0};
                div_dvs = sum_reg;
                div_n   = rwn_pkg::DIV_CW'(97);
            end
            ST_SROOT:
            begin
                sq_x = {1'b0, div_quot};
                sq_n = rwn_pkg::SQ_CW'(49);
            end
            ST_RMUL1:
            begin
                mul_a = rwn_pkg::MUL_AW'(rwn_pkg::mag32(v_rd));
                mul_b = {scale_reg, 32'd0};
                mul_n = rwn_pkg::MUL_CW'(32);
            end
            ST_RMUL2:
            begin
                mul_a = rwn_pkg::MUL_AW'(rwn_pkg::mag32(norm_reg));
                mul_b = {root_rd, 32'd0};
                mul_n = rwn_pkg::MUL_CW'(32);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            grid_log_reg   <= 1'b1;
            step_reg       <= rwn_pkg::STEP_RESET;
            sum_reg        <= '0;
            scale_reg      <= '0;
            count_reg      <= '0;
            closed_reg     <= 1'b0;
            mul_go_reg     <= 1'b0;
            div_go_reg     <= 1'b0;
            sq_go_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            sample_reg     <= '0;
            smag_reg       <= '0;
            rad_reg        <= '0;
            last_reg       <= 1'b0;
            idx_reg        <= '0;
            root_reg       <= '0;
            val_reg        <= '0;
            norm_reg       <= '0;
            resc_reg       <= '0;
            status_reg     <= rwn_pkg::STATUS_OK;
            out_index_reg  <= '0;
            out_norm_reg   <= '0;
            out_resc_reg   <= '0;
            out_status_reg <= rwn_pkg::STATUS_OK;
        end
        else
        begin
            mul_go_reg <= 1'b0;
            div_go_reg <= 1'b0;
            sq_go_reg  <= 1'b0;
            if (rsp.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid)
            begin
                case (cfg.index)
                    rwn_pkg::REG_GRID_LOG:   grid_log_reg <= cfg.data[0];
                    rwn_pkg::REG_STEP_WIDTH: step_reg     <= cfg.data;
                    default:                 grid_log_reg <= grid_log_reg;
                endcase
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (req.cmd == rwn_pkg::CMD_LOAD)
                        begin
                            sample_reg <= req.sample;
                            smag_reg   <= rwn_pkg::mag32(req.sample);
                            rad_reg    <= req.radius;
                            last_reg   <= req.last;
                            if (closed_reg)
                            begin
                                closed_reg <= 1'b0;
                                sum_reg    <= '0;
                                count_reg  <= '0;
                            end
                            if (full)
                                state_reg <= ST_FIN;
                            else
                            begin
                                state_reg  <= ST_MUL1;
                                mul_go_reg <= 1'b1;
                            end
                        end
                        else
                        begin
                            idx_reg  <= req.index;
                            norm_reg <= '0;
                            resc_reg <= '0;
                            if (!closed_reg)
                            begin
                                status_reg <= rwn_pkg::STATUS_EARLY;
                                state_reg  <= ST_OUT;
                            end
                            else if (sum_reg == 64'd0)
                            begin
                                status_reg <= rwn_pkg::STATUS_ZERO;
                                state_reg  <= ST_OUT;
                            end
                            else if (32'(req.index) >= 32'(DEPTH))
                            begin
                                status_reg <= rwn_pkg::STATUS_OK;
                                state_reg  <= ST_OUT;
                            end
                            else
                            begin
                                status_reg <= rwn_pkg::STATUS_OK;
                                state_reg  <= ST_ADDR;
                            end
                        end
                    end
                end
                ST_MUL1:
                begin
                    if (mul_done)
                    begin
                        state_reg  <= ST_MUL2;
                        mul_go_reg <= 1'b1;
                    end
                end
                ST_MUL2:
                begin
                    if (mul_done)
                    begin
                        state_reg  <= ST_MUL3;
                        mul_go_reg <= 1'b1;
                    end
                end
                ST_MUL3:
                begin
                    if (mul_done)
                    begin
                        sum_reg <= sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
                        if (grid_log_reg)
                        begin
                            state_reg <= ST_ROOT;
                            sq_go_reg <= 1'b1;
                        end
                        else
                        begin
                            root_reg  <= rwn_pkg::ONE_Q16;
                            val_reg   <= sample_reg;
                            state_reg <= ST_WRITE;
                        end
                    end
                end
                ST_ROOT:
                begin
                    if (sq_done)
                    begin
                        root_reg <= 32'(sq_root);
                        if (sq_root == '0)
                        begin
                            val_reg   <= (smag_reg == 32'd0) ? 32'd0 :
                                         rwn_pkg::sat32(sample_reg[31], 64'hFFFF_FFFF_FFFF_FFFF);
                            state_reg <= ST_WRITE;
                        end
                        else
                        begin
                            state_reg  <= ST_DIV;
                            div_go_reg <= 1'b1;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        val_reg   <= rwn_pkg::sat32(sample_reg[31], div_quot[63:0]);
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!last_reg)
                        state_reg <= ST_IDLE;
                    else if (sum_reg == 64'd0)
                    begin
                        scale_reg  <= '0;
                        closed_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg  <= ST_SDIV;
                        div_go_reg <= 1'b1;
                    end
                end
                ST_SDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_SROOT;
                        sq_go_reg <= 1'b1;
                    end
                end
                ST_SROOT:
                begin
                    if (sq_done)
                    begin
                        scale_reg  <= (|sq_root[48:32]) ? 32'hFFFF_FFFF : sq_root[31:0];
                        closed_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                ST_ADDR:
                begin
                    state_reg  <= ST_RMUL1;
                    mul_go_reg <= 1'b1;
                end
                ST_RMUL1:
                begin
                    if (mul_done)
                    begin
                        norm_reg   <= rwn_pkg::sat32(v_rd[31], mul_prod[87:24]);
                        state_reg  <= ST_RMUL2;
                        mul_go_reg <= 1'b1;
                    end
                end
                ST_RMUL2:
                begin
                    if (mul_done)
                    begin
                        resc_reg  <= rwn_pkg::sat32(norm_reg[31], mul_prod[79:16]);
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_index_reg  <= idx_reg;
                        out_norm_reg   <= norm_reg;
                        out_resc_reg   <= resc_reg;
                        out_status_reg <= status_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    rwn_mul #(
        .AW (rwn_pkg::MUL_AW),
        .BW (rwn_pkg::MUL_BW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_go_reg),
        .a     (mul_a),
        .b     (mul_b),
        .nbits (mul_n),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    rwn_div #(
        .NW (rwn_pkg::DIV_NW),
        .DW (rwn_pkg::DIV_DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_go_reg),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .nbits    (div_n),
        .quot     (div_quot),
        .done     (div_done)
    );

    rwn_sqrt #(
        .RW (rwn_pkg::SQ_RW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_go_reg),
        .radicand (sq_x),
        .npairs   (sq_n),
        .root     (sq_root),
        .done     (sq_done)
    );

    rwn_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (val_reg),
        .raddr (AW'(idx_reg)),
        .rdata (v_rd)
    );

    rwn_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_root_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (root_reg),
        .raddr (AW'(idx_reg)),
        .rdata (root_rd)
    );

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_index  = out_index_reg;
    assign rsp.normalised = out_norm_reg;
    assign rsp.rescaled   = out_resc_reg;
    assign rsp.status     = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("load count beyond depth");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> count_reg < CW'(DEPTH))
        else $error("store write with vector full");

    a_close_path: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(closed_reg) |-> ($past(state_reg) == ST_SROOT || $past(state_reg) == ST_FIN))
        else $error("vector closed outside scale path");

    a_mul_go: assert property (@(posedge clk) disable iff (!rst_n)
        mul_go_reg |-> (state_reg == ST_MUL1 || state_reg == ST_MUL2 ||
                        state_reg == ST_MUL3 || state_reg == ST_RMUL1 ||
                        state_reg == ST_RMUL2))
        else $error("multiplier started outside a multiply step");
endmodule

@@ design/rwn_ram.sv @@
// rwn_ram: generic single write port ram with registered read
// depends on nothing
module rwn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

@@ design/rwn_mul.sv @@
// rwn_mul: shift-add multiplier, one multiplier bit per cycle, msb first
// depends on rwn_pkg
module rwn_mul #(
    parameter int AW = rwn_pkg::MUL_AW,
    parameter int BW = rwn_pkg::MUL_BW
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [AW-1:0]             a,
    input  logic [BW-1:0]             b,
    input  logic [$clog2(BW+1)-1:0]   nbits,
    output logic [AW+BW-1:0]          prod,
    output logic                      done
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [PW-1:0] acc_reg;
    logic [PW-1:0] acc_next;
    logic [AW-1:0] a_reg;
    logic [BW-1:0] b_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    assign acc_next = {acc_reg[PW-2:0], 1'b0} + (b_reg[BW-1] ? PW'(a_reg) : '0);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[BW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;
endmodule

@@ design/rwn_div.sv @@
// rwn_div: restoring divider, one quotient bit per cycle
// depends on rwn_pkg
module rwn_div #(
    parameter int NW = rwn_pkg::DIV_NW,
    parameter int DW = rwn_pkg::DIV_DW
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NW-1:0]           dividend,
    input  logic [DW-1:0]           divisor,
    input  logic [$clog2(NW+1)-1:0] nbits,
    output logic [NW-1:0]           quot,
    output logic                    done
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] d_reg;
    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          ge;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    assign rem_sh = {rem_reg, q_reg[NW-1]};
    assign ge     = rem_sh >= {1'b0, d_reg};
    assign diff   = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= nbits;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot = q_reg;
    assign done = done_reg;
endmodule

@@ design/rwn_sqrt.sv @@
// rwn_sqrt: digit-by-digit integer square root, one root bit per cycle
// depends on rwn_pkg
module rwn_sqrt #(
    parameter int RW = rwn_pkg::SQ_RW
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [RW-1:0]               radicand,
    input  logic [$clog2(RW/2+1)-1:0]   npairs,
    output logic [RW/2-1:0]             root,
    output logic                        done
);
    localparam int QW  = RW / 2;
    localparam int RMW = QW + 2;
    localparam int CW  = $clog2(QW + 1);

    logic [RW-1:0]  x_reg;
    logic [QW-1:0]  root_reg;
    logic [RMW-1:0] rem_reg;
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;
    logic           ge;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    assign rem_sh = {rem_reg[RMW-3:0], x_reg[RW-1:RW-2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[RW-3:0], 2'b00};
            root_reg <= {root_reg[QW-2:0], ge};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= npairs;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;
endmodule

@@ sim/rwn_test_ifs.sv @@
// rwn_test_ifs: testbench package with the expected read word layout
// depends on nothing
`timescale 1ns / 100ps
package rwn_test_defs;
    typedef struct packed {
        logic [9:0]  out_index;
        logic [31:0] normalised;
        logic [31:0] rescaled;
        logic [1:0]  status;
    } read_word_t;
endpackage

@@ sim/radial_wavefunction_normaliser_core_test.sv @@
// radial_wavefunction_normaliser_core_test: self-checking testbench for the normaliser core
// a behavioral predictor computes each read result; depends on rwn_pkg, rwn_ifs, rwn_test_ifs
`timescale 1ns / 100ps
module radial_wavefunction_normaliser_core_test;

    localparam int DEPTH = 256;
    localparam int AW = $clog2(DEPTH);
    localparam longint CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #1 clk = ~clk;

    rwn_cfg_if cfg();
    rwn_req_if req();
    rwn_rsp_if rsp();

    radial_wavefunction_normaliser_core #(.DEPTH(DEPTH)) u_dut (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .req(req), .rsp(rsp)
    );

    // predictor state
    logic [31:0] vals [DEPTH];
    logic [31:0] roots [DEPTH];
    logic [63:0] sum_sq;
    logic [31:0] scale;
    int          n_loaded;
    logic        closed;
    logic        log_grid;
    logic [31:0] dx;

    rwn_test_defs::read_word_t expected_q[$];
    int  errors = 0;
    int  mismatches = 0;
    longint cycles = 0;
    bit  hold_off = 0;
    int  gap_left = 0;

    function automatic logic [31:0] sat_word(input logic neg, input logic [127:0] mag);
        if (neg)
            return (mag >= 128'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
        return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic [31:0] int_root(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] inverse_root(input logic [63:0] s);
        logic [31:0]  r;
        logic [31:0]  c;
        logic [127:0] p;
        r = 0;
        if (s == 0) return 0;
        for (int b = 31; b >= 0; b--)
        begin
            c = r | (32'd1 << b);
            p = {96'd0, c} * {96'd0, c} * {64'd0, s};
            if (p <= (128'd1 << 96)) r = c;
        end
        return r;
    endfunction

    task automatic predict_load(input logic [31:0] s, input logic [31:0] rad, input logic lst);
        logic         neg;
        logic [127:0] m;
        logic [127:0] t;
        logic [191:0] w;
        logic [127:0] tot;
        logic [31:0]  rt;
        logic [31:0]  v;
        neg = s[31];
        m = {96'd0, rwn_pkg::mag32(s)};
        if (closed)
        begin
            closed = 0;
            sum_sq = 0;
            n_loaded = 0;
        end
        if (n_loaded < DEPTH)
        begin
            t = m * {96'd0, rad};
            t = t * t;
            w = {64'd0, t} * {160'd0, dx};
            tot = (|w[191:136]) ? {64'd0, 64'hFFFF_FFFF_FFFF_FFFF} : {64'd0, w[135:72]};
            tot = tot + {64'd0, sum_sq};
            sum_sq = (|tot[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : tot[63:0];
            if (log_grid)
            begin
                rt = int_root({20'd0, rad, 12'd0});
                if (rt == 0)
                    v = (m == 0) ? 32'd0 : sat_word(neg, 128'hFFFF_FFFF_FFFF);
                else
                    v = sat_word(neg, (m << 16) / {96'd0, rt});
            end
            else
            begin
                rt = rwn_pkg::ONE_Q16;
                v = s;
            end
            vals[AW'(n_loaded)] = v;
            roots[AW'(n_loaded)] = rt;
            n_loaded++;
        end
        if (lst)
        begin
            scale = inverse_root(sum_sq);
            closed = 1;
        end
    endtask

    function automatic rwn_test_defs::read_word_t predict_read(input logic [9:0] idx);
        rwn_test_defs::read_word_t w;
        logic [127:0] vm;
        logic [127:0] nm;
        w.out_index = idx;
        w.normalised = 0;
        w.rescaled = 0;
        w.status = rwn_pkg::STATUS_OK;
        if (!closed)
            w.status = rwn_pkg::STATUS_EARLY;
        else if (sum_sq == 0)
            w.status = rwn_pkg::STATUS_ZERO;
        else if (32'(idx) < 32'(DEPTH))
        begin
            vm = {96'd0, rwn_pkg::mag32(vals[AW'(idx)])};
            w.normalised = sat_word(vals[AW'(idx)][31], (vm * {96'd0, scale}) >> 24);
            nm = {96'd0, rwn_pkg::mag32(w.normalised)};
            w.rescaled = sat_word(w.normalised[31], (nm * {96'd0, roots[AW'(idx)]}) >> 16);
        end
        return w;
    endfunction

    // drop the request and scramble the idle payload
    task automatic idle_req();
        req.valid <= 1'b0;
        req.cmd <= 1'($urandom);
        req.sample <= $urandom;
        req.radius <= $urandom;
        req.index <= 10'($urandom);
        req.last <= 1'($urandom);
    endtask

    task automatic send_word(input logic c, input logic [31:0] s, input logic [31:0] rad,
                             input logic [9:0] idx, input logic lst);
        if (gap_left == 0 && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 12);
        if (gap_left > 0)
        begin
            idle_req();
            while (gap_left > 0)
            begin
                @(negedge clk);
                gap_left--;
            end
        end
        req.valid <= 1'b1;
        req.cmd <= c;
        req.sample <= s;
        req.radius <= rad;
        req.index <= idx;
        req.last <= lst;
        do @(posedge clk); while (!req.ready);
        if (c == rwn_pkg::CMD_LOAD)
            predict_load(s, rad, lst);
        else
            expected_q.push_back(predict_read(idx));
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
        idle_req();
        while (expected_q.size() != 0) @(negedge clk);
        repeat (400) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= d;
        do @(posedge clk); while (!cfg.ready);
        if (idx == rwn_pkg::REG_GRID_LOG) log_grid = d[0];
        else dx = d;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(0, 32'h0FFF_FFFF);
            4: return 32'd0 - $urandom_range(0, 32'h0FFF_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_radius();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(32'h0001_0000, 32'h0100_0000);
            default: return $urandom;
        endcase
    endfunction

    // one vector of n loads followed by reads of loaded positions
    task automatic run_vector(input int n, input int reads);
        for (int i = 0; i < n; i++)
            send_word(rwn_pkg::CMD_LOAD, rand_sample(), rand_radius(), 10'($urandom),
                      i == n - 1);
        for (int i = 0; i < reads; i++)
            send_word(rwn_pkg::CMD_READ, $urandom, $urandom, 10'($urandom_range(0, n - 1)),
                      1'($urandom));
    endtask

    task automatic test_directed();
        send_word(rwn_pkg::CMD_READ, 32'd0, 32'd0, 10'd0, 1'b0);
        send_word(rwn_pkg::CMD_READ, 32'd0, 32'd0, 10'h3FF, 1'b0);
        send_word(rwn_pkg::CMD_LOAD, 32'h8000_0000, 32'h0010_0000, 10'h3FF, 1'b0);
        send_word(rwn_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 10'd0, 1'b0);
        send_word(rwn_pkg::CMD_LOAD, 32'h1000_0000, 32'd0, 10'd0, 1'b0);
        send_word(rwn_pkg::CMD_LOAD, 32'd0, 32'd0, 10'd0, 1'b0);
        send_word(rwn_pkg::CMD_LOAD, 32'hF000_0000, 32'd0, 10'd0, 1'b1);
        for (int i = 0; i < 5; i++)
            send_word(rwn_pkg::CMD_READ, $urandom, $urandom, i[9:0], 1'b1);
        send_word(rwn_pkg::CMD_LOAD, 32'd0, 32'h0010_0000, 10'd0, 1'b1);
        send_word(rwn_pkg::CMD_READ, 32'd0, 32'd0, 10'd0, 1'b0);
        send_word(rwn_pkg::CMD_LOAD, 32'h0000_0001, 32'h0000_0001, 10'd0, 1'b1);
        send_word(rwn_pkg::CMD_READ, 32'd0, 32'd0, 10'd0, 1'b0);
    endtask

    task automatic test_linear_grid();
        write_reg(rwn_pkg::REG_GRID_LOG, 32'd0);
        write_reg(rwn_pkg::REG_STEP_WIDTH, 32'hFFFF_FFFF);
        run_vector(4, 6);
        write_reg(rwn_pkg::REG_STEP_WIDTH, 32'd1);
        run_vector(5, 6);
        write_reg(rwn_pkg::REG_STEP_WIDTH, $urandom_range(1, 32'h0400_0000));
        for (int k = 0; k < 10; k++) run_vector($urandom_range(1, 8), $urandom_range(1, 8));
    endtask

    task automatic test_log_grid();
        write_reg(rwn_pkg::REG_GRID_LOG, 32'd1);
        write_reg(rwn_pkg::REG_STEP_WIDTH, rwn_pkg::STEP_RESET);
        for (int k = 0; k < 14; k++) run_vector($urandom_range(1, 8), $urandom_range(1, 8));
    endtask

    // fill past depth once: extra loads are dropped but still close the vector
    task automatic test_overflow();
        write_reg(rwn_pkg::REG_STEP_WIDTH, $urandom_range(1, 32'h0010_0000));
        for (int i = 0; i < DEPTH + 3; i++)
            send_word(rwn_pkg::CMD_LOAD, rand_sample(), rand_radius(), 10'd0, i == DEPTH + 2);
        for (int i = 0; i < 8; i++)
            send_word(rwn_pkg::CMD_READ, 32'd0, 32'd0, (i == 0) ? 10'h3FF : 10'($urandom),
                      1'b0);
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        for (int i = 0; i < 6; i++)
            send_word(rwn_pkg::CMD_READ, 32'd0, 32'd0, 10'($urandom_range(0, 3)), 1'b0);
        hold_off = 0;
        for (int k = 0; k < 14; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_word(1'($urandom), $urandom, $urandom, 10'($urandom), 1'($urandom));
            else
                run_vector($urandom_range(1, 6), $urandom_range(1, 8));
        end
    endtask

    // receiver: stalls on its own pattern, long hold-off on request
    initial
    begin
        int held;
        rsp.ready = 1'b0;
        held = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off && held < 1500)
            begin
                rsp.ready <= 1'b0;
                held++;
            end
            else if (cycles[9])
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        rwn_test_defs::read_word_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10) $display("unexpected word idx=%0d", rsp.out_index);
            end
            else
            begin
                want = expected_q.pop_front();
                if (rsp.out_index !== want.out_index || rsp.normalised !== want.normalised ||
                    rsp.rescaled !== want.rescaled || rsp.status !== want.status)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch exp %h %h %h %0d got %h %h %h %0d",
                                 want.out_index, want.normalised, want.rescaled, want.status,
                                 rsp.out_index, rsp.normalised, rsp.rescaled, rsp.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        req.valid = 0; req.cmd = 0; req.sample = 0; req.radius = 0;
        req.index = 0; req.last = 0;
        cfg.valid = 0; cfg.index = 0; cfg.data = 0;
        closed = 0; sum_sq = 0; scale = 0; n_loaded = 0;
        log_grid = 1; dx = rwn_pkg::STEP_RESET;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_linear_grid();
        test_log_grid();
        test_overflow();
        test_backpressure();
        idle_req();
        while (expected_q.size() != 0) @(negedge clk);
        repeat (500) @(negedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ radial_wavefunction_normaliser_core.f @@
design/rwn_pkg.sv
design/rwn_ifs.sv
design/rwn_ram.sv
design/rwn_mul.sv
design/rwn_div.sv
design/rwn_sqrt.sv
design/radial_wavefunction_normaliser_core.sv
sim/rwn_test_ifs.sv
sim/radial_wavefunction_normaliser_core_test.sv
